// ===== hdl/searchable_fifo_with_keyed_removal_defines.svh =====
// assertion macros for the checker file
// no dependencies
`ifndef SEARCHABLE_FIFO_WITH_KEYED_REMOVAL_DEFINES_SVH
`define SEARCHABLE_FIFO_WITH_KEYED_REMOVAL_DEFINES_SVH

// same-cycle implication
`define SFKR_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfkr assertion failed");

// next-cycle implication
`define SFKR_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfkr assertion failed");

`endif

// ===== hdl/sfkr_pkg.sv =====
// shared constants, command codes and cell control type for the keyed queue
// no dependencies
package sfkr_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int ID_BITS      = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int COUNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_REMOVE = 2'd3
  } sfkr_action_t;

  typedef struct packed {
    logic load;   // take the pushed record
    logic shift;  // take the record of the next cell toward the tail
  } sfkr_ctrl_t;

endpackage

// ===== hdl/sfkr_cell.sv =====
// one queue slot: occupancy, identifier, payload and key compare
// depends on sfkr_pkg
module sfkr_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  sfkr_pkg::sfkr_ctrl_t            ctrl,
  input  logic [sfkr_pkg::ID_BITS-1:0]      new_id,
  input  logic [sfkr_pkg::PAYLOAD_BITS-1:0] new_payload,
  input  logic                            nb_valid,
  input  logic [sfkr_pkg::ID_BITS-1:0]      nb_id,
  input  logic [sfkr_pkg::PAYLOAD_BITS-1:0] nb_payload,
  input  logic [sfkr_pkg::ID_BITS-1:0]      key,
  output logic                            valid,
  output logic [sfkr_pkg::ID_BITS-1:0]      id,
  output logic [sfkr_pkg::PAYLOAD_BITS-1:0] payload,
  output logic                            match
);
  import sfkr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= nb_valid;
    end else if (ctrl.load) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      id      <= nb_id;
      payload <= nb_payload;
    end else if (ctrl.load) begin
      id      <= new_id;
      payload <= new_payload;
    end
  end

  assign match = valid && (id == key);

endmodule

// ===== hdl/searchable_fifo_with_keyed_removal.sv =====
// keyed queue: one command per transfer, result registered on acceptance
// throughput one command per cycle while the result side takes every cycle
// every cell compares its key in parallel; removal shifts the later cells forward
// synchronous active-high reset empties the queue and drops any pending result
// depends on sfkr_pkg and sfkr_cell
module searchable_fifo_with_keyed_removal (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        action,
  input  logic [sfkr_pkg::ID_BITS-1:0]      item_id,
  input  logic [sfkr_pkg::PAYLOAD_BITS-1:0] item_payload,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              hit,
  output logic [sfkr_pkg::PAYLOAD_BITS-1:0] hit_payload,
  output logic                              push_dropped,
  output logic                              queue_empty,
  output logic [sfkr_pkg::ID_BITS-1:0]      head_id,
  output logic [sfkr_pkg::PAYLOAD_BITS-1:0] head_payload,
  output logic [sfkr_pkg::COUNT_BITS-1:0]   record_count
);
  import sfkr_pkg::*;

  logic [QUEUE_DEPTH-1:0]  cell_valid;
  logic [QUEUE_DEPTH-1:0]  cell_match;
  logic [ID_BITS-1:0]      cell_id      [QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0] cell_payload [QUEUE_DEPTH];
  sfkr_ctrl_t              cell_ctrl    [QUEUE_DEPTH];

  logic [QUEUE_DEPTH-1:0]  tail_slot;
  logic [QUEUE_DEPTH-1:0]  first_hit;
  logic [QUEUE_DEPTH-1:0]  rm_shift;
  logic                    any_hit;
  logic [PAYLOAD_BITS-1:0] sel_payload;
  logic                    xfer_in;
  logic                    is_full;
  sfkr_action_t            act;
  logic [COUNT_BITS-1:0]   count, count_next;
  logic                    do_load;
  logic [QUEUE_DEPTH-1:0]  shift_vec;
  logic                    hit_next, dropped_next;

  assign act     = sfkr_action_t'(action);
  assign xfer_in = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;
  assign is_full = (count == COUNT_BITS'(QUEUE_DEPTH));

  // first empty slot after the occupied prefix; none when full
  assign tail_slot = ~cell_valid & {cell_valid[QUEUE_DEPTH-2:0], 1'b1};

  // lowest matching slot, and every slot from it toward the tail
  assign any_hit   = |cell_match;
  assign first_hit = cell_match & (~cell_match + 1'b1);
  assign rm_shift  = ~(first_hit - 1'b1);

  always_comb begin
    sel_payload = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      sel_payload = sel_payload | ({PAYLOAD_BITS{first_hit[i]}} & cell_payload[i]);
    end
  end

  always_comb begin
    do_load      = 1'b0;
    shift_vec    = '0;
    hit_next     = 1'b0;
    dropped_next = 1'b0;
    count_next   = count;
    unique case (act)
      ACT_PUSH: begin
        do_load      = !is_full;
        dropped_next = is_full;
        if (!is_full) begin
          count_next = count + 1'b1;
        end
      end
      ACT_POP: begin
        shift_vec = {QUEUE_DEPTH{cell_valid[0]}};
        if (cell_valid[0]) begin
          count_next = count - 1'b1;
        end
      end
      ACT_FIND: begin
        hit_next = any_hit;
      end
      ACT_REMOVE: begin
        hit_next  = any_hit;
        shift_vec = rm_shift;
        if (any_hit) begin
          count_next = count - 1'b1;
        end
      end
      default: begin
        do_load = 1'b0;
      end
    endcase
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic                    nb_valid;
    logic [ID_BITS-1:0]      nb_id;
    logic [PAYLOAD_BITS-1:0] nb_payload;

    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign nb_valid   = 1'b0;
      assign nb_id      = '0;
      assign nb_payload = '0;
    end else begin : g_mid
      assign nb_valid   = cell_valid[g+1];
      assign nb_id      = cell_id[g+1];
      assign nb_payload = cell_payload[g+1];
    end

    assign cell_ctrl[g].load  = xfer_in && do_load && tail_slot[g];
    assign cell_ctrl[g].shift = xfer_in && shift_vec[g];

    sfkr_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (cell_ctrl[g]),
      .new_id      (item_id),
      .new_payload (item_payload),
      .nb_valid    (nb_valid),
      .nb_id       (nb_id),
      .nb_payload  (nb_payload),
      .key         (item_id),
      .valid       (cell_valid[g]),
      .id          (cell_id[g]),
      .payload     (cell_payload[g]),
      .match       (cell_match[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (xfer_in) begin
        count <= count_next;
      end
      if (xfer_in) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer_in) begin
      hit          <= hit_next;
      hit_payload  <= hit_next ? sel_payload : '0;
      push_dropped <= dropped_next;
    end
  end

  // state only moves on an input transfer, which waits for the result to go
  assign queue_empty  = !cell_valid[0];
  assign head_id      = cell_valid[0] ? cell_id[0] : '0;
  assign head_payload = cell_valid[0] ? cell_payload[0] : '0;
  assign record_count = count;

endmodule

// ===== hdl/sfkr_checker.sv =====
// port-level checks of the keyed queue, bound to the top level
// depends on sfkr_pkg and searchable_fifo_with_keyed_removal_defines.svh
`include "searchable_fifo_with_keyed_removal_defines.svh"

module sfkr_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              hit,
  input logic [sfkr_pkg::PAYLOAD_BITS-1:0] hit_payload,
  input logic                              push_dropped,
  input logic                              queue_empty,
  input logic [sfkr_pkg::ID_BITS-1:0]      head_id,
  input logic [sfkr_pkg::PAYLOAD_BITS-1:0] head_payload,
  input logic [sfkr_pkg::COUNT_BITS-1:0]   record_count
);
  import sfkr_pkg::*;

  logic                                 head_zero;
  logic                                 at_full;
  logic [PAYLOAD_BITS+COUNT_BITS-1:0]   held_view;

  assign head_zero = (head_id == '0) && (head_payload == '0);
  assign at_full   = (record_count == COUNT_BITS'(QUEUE_DEPTH));
  // fields that must not move while a result waits
  assign held_view = {hit_payload, record_count};

  `SFKR_ASSERT_NOW(a_empty_count, clk, rst, out_valid, queue_empty == (record_count == '0))
  `SFKR_ASSERT_NOW(a_empty_head, clk, rst, out_valid && queue_empty, head_zero)
  `SFKR_ASSERT_NOW(a_miss_zero, clk, rst, out_valid && !hit, hit_payload == '0)
  `SFKR_ASSERT_NOW(a_drop_full, clk, rst, out_valid && push_dropped, !hit && at_full)
  `SFKR_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(held_view))

endmodule

bind searchable_fifo_with_keyed_removal sfkr_checker u_sfkr_checker (.*);

// ===== tb/testbench.sv =====
// self-checking bench for the keyed queue: directed corner cases, then random bursts
// a scoreboard class tracks the queue contents and checks every result in order
// depends on sfkr_pkg and the searchable_fifo_with_keyed_removal rtl
module testbench;
  import sfkr_pkg::*;

  localparam int RANDOM_ITEMS = 750;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 80;

  typedef struct packed {
    logic [ID_BITS-1:0]      id;
    logic [PAYLOAD_BITS-1:0] payload;
  } record_t;

  typedef struct packed {
    logic                    hit;
    logic [PAYLOAD_BITS-1:0] hit_payload;
    logic                    push_dropped;
    logic                    queue_empty;
    logic [ID_BITS-1:0]      head_id;
    logic [PAYLOAD_BITS-1:0] head_payload;
    logic [COUNT_BITS-1:0]   record_count;
  } result_t;

  class queue_tracker;
    record_t records[$];
    result_t pending_results[$];
    int      mismatches;
    int      checked;
    int      action_seen[4];
    int      dropped_seen;
    int      hits_seen;

    // update the tracked queue for one accepted command and queue up its result
    function void note_command(sfkr_action_t act, logic [ID_BITS-1:0] key,
                               logic [PAYLOAD_BITS-1:0] pl);
      result_t r;
      record_t rec;
      int      pos;
      r   = '0;
      pos = -1;
      action_seen[int'(act)]++;
      case (act)
        ACT_PUSH: begin
          if (records.size() >= QUEUE_DEPTH) begin
            r.push_dropped = 1'b1;
            dropped_seen++;
          end else begin
            rec.id      = key;
            rec.payload = pl;
            records.push_back(rec);
          end
        end
        ACT_POP: begin
          if (records.size() > 0) void'(records.pop_front());
        end
        default: begin
          // first match counted from the head
          for (int i = 0; i < records.size(); i++) begin
            if (pos < 0 && records[i].id == key) pos = i;
          end
          if (pos >= 0) begin
            r.hit         = 1'b1;
            r.hit_payload = records[pos].payload;
            hits_seen++;
            if (act == ACT_REMOVE) records.delete(pos);
          end
        end
      endcase
      r.queue_empty = (records.size() == 0);
      if (records.size() > 0) begin
        r.head_id      = records[0].id;
        r.head_payload = records[0].payload;
      end
      r.record_count = COUNT_BITS'(records.size());
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing outstanding, expected none, got %h", $time, got);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      compare_field("hit", 64'(want.hit), 64'(got.hit));
      compare_field("hit_payload", 64'(want.hit_payload), 64'(got.hit_payload));
      compare_field("push_dropped", 64'(want.push_dropped), 64'(got.push_dropped));
      compare_field("queue_empty", 64'(want.queue_empty), 64'(got.queue_empty));
      compare_field("head_id", 64'(want.head_id), 64'(got.head_id));
      compare_field("head_payload", 64'(want.head_payload), 64'(got.head_payload));
      compare_field("record_count", 64'(want.record_count), 64'(got.record_count));
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic [1:0]              action;
  logic [ID_BITS-1:0]      item_id;
  logic [PAYLOAD_BITS-1:0] item_payload;
  logic                    out_valid;
  logic                    out_ready;
  logic                    hit;
  logic [PAYLOAD_BITS-1:0] hit_payload;
  logic                    push_dropped;
  logic                    queue_empty;
  logic [ID_BITS-1:0]      head_id;
  logic [PAYLOAD_BITS-1:0] head_payload;
  logic [COUNT_BITS-1:0]   record_count;

  queue_tracker tracker = new();
  result_t      observed;
  bit           hold_output;
  int           cycle_count;

  searchable_fifo_with_keyed_removal u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .item_id      (item_id),
    .item_payload (item_payload),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .hit_payload  (hit_payload),
    .push_dropped (push_dropped),
    .queue_empty  (queue_empty),
    .head_id      (head_id),
    .head_payload (head_payload),
    .record_count (record_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // results are checked before the same-edge command is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        observed = '{hit, hit_payload, push_dropped, queue_empty, head_id, head_payload,
                     record_count};
        tracker.check_result(observed);
      end
      if (in_valid && in_ready) begin
        tracker.note_command(sfkr_action_t'(action), item_id, item_payload);
      end
    end
  end

  // result side: changing stall patterns, plus one long hold-off on request
  initial begin
    int ready_mode;
    int rx_cycle;
    out_ready  = 1'b0;
    ready_mode = 0;
    rx_cycle   = 0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle % 50 == 0) ready_mode = $urandom_range(0, 3);
      if (hold_output) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_output = 1'b0;
      end else begin
        case (ready_mode)
          0:       out_ready = 1'b1;
          1:       out_ready = ($urandom_range(0, 1) == 1);
          2:       out_ready = (rx_cycle % 4 != 0);
          default: out_ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run timed out", $time);
    $display("tb: failure");
    $finish;
  end

  // offer one command and hold it until the transfer happens
  task automatic send_cmd(sfkr_action_t act, logic [ID_BITS-1:0] key,
                          logic [PAYLOAD_BITS-1:0] pl);
    @(negedge clk);
    in_valid     = 1'b1;
    action       = act;
    item_id      = key;
    item_payload = pl;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_cycles(int n);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic pick_and_send(bit filling);
    int                      roll;
    sfkr_action_t            act;
    logic [ID_BITS-1:0]      key;
    logic [PAYLOAD_BITS-1:0] pl;
    roll = $urandom_range(0, 99);
    if (filling) begin
      if (roll < 50)      act = ACT_PUSH;
      else if (roll < 60) act = ACT_POP;
      else if (roll < 80) act = ACT_FIND;
      else                act = ACT_REMOVE;
    end else begin
      if (roll < 15)      act = ACT_PUSH;
      else if (roll < 45) act = ACT_POP;
      else if (roll < 65) act = ACT_FIND;
      else                act = ACT_REMOVE;
    end
    // mostly keys that are stored or collide, so searches hit and duplicates form
    roll = $urandom_range(0, 9);
    if (roll < 4 && tracker.records.size() > 0)
      key = tracker.records[$urandom_range(0, tracker.records.size() - 1)].id;
    else if (roll < 7) key = ID_BITS'($urandom_range(0, 7));
    else if (roll == 7) key = $urandom_range(0, 1) ? '1 : '0;
    else key = ID_BITS'($urandom);
    roll = $urandom_range(0, 9);
    if (roll == 0)      pl = '0;
    else if (roll == 1) pl = '1;
    else                pl = PAYLOAD_BITS'($urandom);
    send_cmd(act, key, pl);
  endtask

  initial begin
    int burst_left;
    bit filling;
    rst          = 1'b1;
    in_valid     = 1'b0;
    action       = ACT_PUSH;
    item_id      = '0;
    item_payload = '0;
    hold_output  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty queue corners
    send_cmd(ACT_POP, '0, '0);
    send_cmd(ACT_FIND, '0, '0);
    send_cmd(ACT_REMOVE, '1, '1);
    // field extremes and a duplicate key
    send_cmd(ACT_PUSH, '0, '0);
    send_cmd(ACT_PUSH, '1, '1);
    send_cmd(ACT_PUSH, '0, 32'h5a5a_0001);
    send_cmd(ACT_FIND, '0, '0);
    send_cmd(ACT_FIND, '1, '0);
    send_cmd(ACT_FIND, 16'h1234, '0);
    send_cmd(ACT_REMOVE, '0, '0);
    send_cmd(ACT_REMOVE, '0, '0);
    // fill up, then push into a full queue
    for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
      send_cmd(ACT_PUSH, ID_BITS'(k + 1), PAYLOAD_BITS'($urandom));
    end
    send_cmd(ACT_PUSH, 16'h00aa, 32'hdead_beef);
    send_cmd(ACT_FIND, ID_BITS'(QUEUE_DEPTH - 1), '0);
    send_cmd(ACT_REMOVE, 16'd8, '0);
    send_cmd(ACT_POP, '0, '0);
    drain_results();

    burst_left = 0;
    filling    = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) filling = $urandom_range(0, 1);
      if (n == 250) begin
        // stall the result side while commands keep coming
        filling     = 1'b1;
        hold_output = 1'b1;
        burst_left  = 40;
      end
      if (n == 500) drain_results();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
      end
      pick_and_send(filling);
      burst_left--;
    end

    drain_results();
    repeat (10) @(posedge clk);
    $display("tb: %0d commands (push %0d, pop %0d, find %0d, remove %0d), %0d results checked",
             tracker.action_seen.sum(), tracker.action_seen[ACT_PUSH],
             tracker.action_seen[ACT_POP], tracker.action_seen[ACT_FIND],
             tracker.action_seen[ACT_REMOVE], tracker.checked);
    $display("tb: %0d pushes into a full queue, %0d keyed hits, %0d mismatches",
             tracker.dropped_seen, tracker.hits_seen, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/sfkr_pkg.sv
hdl/sfkr_cell.sv
hdl/searchable_fifo_with_keyed_removal.sv
hdl/sfkr_checker.sv
tb/testbench.sv
